>>> rtl/vsrd_pkg.sv
// Shared types and constants of the camera response deframer.
// Used by vsrd_front, vsrd_queue, vsrd_back and the top level; depends on nothing.
`default_nettype none

package vsrd_pkg;

  localparam logic [7:0]  HDR_FIRST   = 8'hFE;
  localparam logic [7:0]  HDR_SECOND  = 8'h00;
  localparam logic [15:0] USER_ID_MAX = 16'd100;

  localparam logic [15:0] COL_LEFT_RST   = 16'd500;
  localparam logic [15:0] COL_RIGHT_RST  = 16'd1100;
  localparam logic [15:0] ROW_TOP_RST    = 16'd400;
  localparam logic [15:0] ROW_BOTTOM_RST = 16'd800;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_AGE_EN     = 3'd0,
    REG_GENDER_EN  = 3'd1,
    REG_EXPR_EN    = 3'd2,
    REG_RECOG_EN   = 3'd3,
    REG_COL_LEFT   = 3'd4,
    REG_COL_RIGHT  = 3'd5,
    REG_ROW_TOP    = 3'd6,
    REG_ROW_BOTTOM = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    KIND_ERR    = 4'd0,
    KIND_LEN    = 4'd1,
    KIND_COUNTS = 4'd2,
    KIND_BODY   = 4'd3,
    KIND_HAND   = 4'd4,
    KIND_FACE   = 4'd5,
    KIND_AGE    = 4'd6,
    KIND_GENDER = 4'd7,
    KIND_EXPR   = 4'd8,
    KIND_RECOG  = 4'd9
  } kind_e;

  typedef struct packed {
    logic        age_en;
    logic        gender_en;
    logic        expr_en;
    logic        recog_en;
    logic [15:0] col_left;
    logic [15:0] col_right;
    logic [15:0] row_top;
    logic [15:0] row_bottom;
  } cfg_t;

  // One completed segment, handed from the parser to the formatter
  typedef struct packed {
    kind_e       kind;
    logic [63:0] data;
    logic        frame_end;
  } token_t;

endpackage

`default_nettype wire

>>> rtl/vsrd_front.sv
// Byte parser: hunts the header, gathers segments and walks the record groups.
// Depends on vsrd_pkg; pushes finished segments into vsrd_queue.
`default_nettype none

module vsrd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      rx_byte_i,
  input  wire vsrd_pkg::cfg_t  cfg_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output vsrd_pkg::token_t     token_o
);

  typedef enum logic [6:0] {
    PH_HUNT0 = 7'b0000001,
    PH_HUNT1 = 7'b0000010,
    PH_LEN   = 7'b0000100,
    PH_COUNT = 7'b0001000,
    PH_BODY  = 7'b0010000,
    PH_HAND  = 7'b0100000,
    PH_FACE  = 7'b1000000
  } phase_e;

  typedef enum logic [4:0] {
    PART_BASE   = 5'b00001,
    PART_AGE    = 5'b00010,
    PART_GENDER = 5'b00100,
    PART_EXPR   = 5'b01000,
    PART_RECOG  = 5'b10000
  } part_e;

  phase_e      phase_q, phase_d;
  part_e       part_q, part_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  body_q, body_d, hand_q, hand_d, face_q, face_d;
  logic [63:0] gather_q, gather_d, gather_new;
  logic        accept;

  function automatic phase_e group_phase(logic [7:0] body, logic [7:0] hand,
                                         logic [7:0] face);
    if (body != 8'd0)      return PH_BODY;
    else if (hand != 8'd0) return PH_HAND;
    else if (face != 8'd0) return PH_FACE;
    else                   return PH_HUNT0;
  endfunction

  // PART_BASE back means no further part is enabled
  function automatic part_e next_part(part_e cur, vsrd_pkg::cfg_t c);
    logic after_base, after_age, after_gender, after_expr;
    after_base   = (cur == PART_BASE);
    after_age    = after_base || (cur == PART_AGE);
    after_gender = after_age || (cur == PART_GENDER);
    after_expr   = after_gender || (cur == PART_EXPR);
    if (after_base && c.age_en)          return PART_AGE;
    else if (after_age && c.gender_en)   return PART_GENDER;
    else if (after_gender && c.expr_en)  return PART_EXPR;
    else if (after_expr && c.recog_en)   return PART_RECOG;
    else                                 return PART_BASE;
  endfunction

  function automatic logic [2:0] last_pos(phase_e ph, part_e pt);
    logic [2:0] r;
    r = 3'd7;
    unique case (ph) inside
      PH_LEN, PH_COUNT: r = 3'd3;
      PH_FACE: begin
        unique case (pt) inside
          PART_AGE, PART_GENDER: r = 3'd2;
          PART_EXPR:             r = 3'd5;
          PART_RECOG:            r = 3'd3;
          default:               r = 3'd7;
        endcase
      end
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      gather_new[8*k +: 8] = (pos_q == 3'(k)) ? rx_byte_i : gather_q[8*k +: 8];
    end
  end

  always_comb begin
    part_e nxt;
    phase_d  = phase_q;
    part_d   = part_q;
    pos_d    = pos_q;
    body_d   = body_q;
    hand_d   = hand_q;
    face_d   = face_q;
    gather_d = gather_q;
    push_o   = 1'b0;
    token_o  = '{kind: vsrd_pkg::KIND_ERR, data: 64'd0, frame_end: 1'b1};
    nxt      = next_part(part_q, cfg_i);
    if (accept) begin
      unique case (phase_q)
        PH_HUNT0: begin
          if (rx_byte_i == vsrd_pkg::HDR_FIRST) begin
            phase_d = PH_HUNT1;
          end else begin
            push_o = 1'b1;
          end
        end
        PH_HUNT1: begin
          if (rx_byte_i == vsrd_pkg::HDR_SECOND) begin
            phase_d  = PH_LEN;
            pos_d    = 3'd0;
            gather_d = 64'd0;
          end else begin
            phase_d = PH_HUNT0;
            push_o  = 1'b1;
          end
        end
        default: begin
          if (pos_q != last_pos(phase_q, part_q)) begin
            pos_d    = pos_q + 3'd1;
            gather_d = gather_new;
          end else begin
            pos_d        = 3'd0;
            gather_d     = 64'd0;
            push_o       = 1'b1;
            token_o.data = gather_new;
            unique case (phase_q)
              PH_LEN: begin
                token_o.kind = vsrd_pkg::KIND_LEN;
                phase_d      = PH_COUNT;
              end
              PH_COUNT: begin
                token_o.kind = vsrd_pkg::KIND_COUNTS;
                body_d  = gather_new[7:0];
                hand_d  = gather_new[15:8];
                face_d  = gather_new[23:16];
                phase_d = group_phase(gather_new[7:0], gather_new[15:8],
                                      gather_new[23:16]);
                part_d  = PART_BASE;
              end
              PH_BODY: begin
                token_o.kind = vsrd_pkg::KIND_BODY;
                body_d  = body_q - 8'd1;
                phase_d = group_phase(body_q - 8'd1, hand_q, face_q);
                part_d  = PART_BASE;
              end
              PH_HAND: begin
                token_o.kind = vsrd_pkg::KIND_HAND;
                hand_d  = hand_q - 8'd1;
                phase_d = group_phase(body_q, hand_q - 8'd1, face_q);
                part_d  = PART_BASE;
              end
              default: begin
                unique case (part_q)
                  PART_AGE:    token_o.kind = vsrd_pkg::KIND_AGE;
                  PART_GENDER: token_o.kind = vsrd_pkg::KIND_GENDER;
                  PART_EXPR:   token_o.kind = vsrd_pkg::KIND_EXPR;
                  PART_RECOG:  token_o.kind = vsrd_pkg::KIND_RECOG;
                  default:     token_o.kind = vsrd_pkg::KIND_FACE;
                endcase
                if (nxt != PART_BASE) begin
                  part_d = nxt;
                end else begin
                  // last part of this face: drop the count and pick the next group
                  face_d  = face_q - 8'd1;
                  phase_d = group_phase(body_q, hand_q, face_q - 8'd1);
                  part_d  = PART_BASE;
                end
              end
            endcase
            token_o.frame_end = (phase_d == PH_HUNT0);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT0;
      part_q   <= PART_BASE;
      pos_q    <= 3'd0;
      body_q   <= 8'd0;
      hand_q   <= 8'd0;
      face_q   <= 8'd0;
      gather_q <= 64'd0;
    end else begin
      phase_q  <= phase_d;
      part_q   <= part_d;
      pos_q    <= pos_d;
      body_q   <= body_d;
      hand_q   <= hand_d;
      face_q   <= face_d;
      gather_q <= gather_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vsrd_queue.sv
// Short segment queue between parser and formatter.
// Depends on vsrd_pkg for the segment type.
`default_nettype none

module vsrd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire vsrd_pkg::token_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output vsrd_pkg::token_t      head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vsrd_pkg::token_t mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

  a_count_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CW'(1))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

>>> rtl/vsrd_back.sv
// Formatter: unpacks a segment into result fields, finds the face grid cell
// and holds the result word in the output register. Depends on vsrd_pkg.
`default_nettype none

module vsrd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire vsrd_pkg::cfg_t   cfg_i,
  input  wire logic             empty_i,
  input  wire vsrd_pkg::token_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [3:0]            kind_o,
  output logic [31:0]           value_a_o,
  output logic [15:0]           value_b_o,
  output logic [15:0]           value_c_o,
  output logic [15:0]           value_d_o,
  output logic [7:0]            value_e_o,
  output logic [7:0]            value_f_o,
  output logic [3:0]            region_o,
  output logic                  frame_end_o
);

  logic        valid_q;
  logic [3:0]  kind_q, kind_d, region_q, region_d;
  logic [31:0] a_q, a_d;
  logic [15:0] b_q, b_d, c_q, c_d, d_q, d_d;
  logic [7:0]  e_q, e_d, f_q, f_d;
  logic        fe_q;
  logic [63:0] g;
  logic [1:0]  col, row;

  assign g     = head_i.data;
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  // first true test wins, so the low column and row take precedence
  always_comb begin
    if (g[15:0] <= cfg_i.col_left)       col = 2'd0;
    else if (g[15:0] <= cfg_i.col_right) col = 2'd1;
    else                                 col = 2'd2;
    if (g[31:16] <= cfg_i.row_top)         row = 2'd0;
    else if (g[31:16] <= cfg_i.row_bottom) row = 2'd1;
    else                                   row = 2'd2;
  end

  always_comb begin
    kind_d   = head_i.kind;
    a_d      = 32'd0;
    b_d      = 16'd0;
    c_d      = 16'd0;
    d_d      = 16'd0;
    e_d      = 8'd0;
    f_d      = 8'd0;
    region_d = 4'd0;
    unique case (head_i.kind) inside
      vsrd_pkg::KIND_LEN: a_d = g[31:0];
      vsrd_pkg::KIND_COUNTS: begin
        a_d = {24'd0, g[7:0]};
        b_d = {8'd0, g[15:8]};
        c_d = {8'd0, g[23:16]};
      end
      vsrd_pkg::KIND_BODY, vsrd_pkg::KIND_HAND, vsrd_pkg::KIND_FACE: begin
        a_d = {16'd0, g[15:0]};
        b_d = g[31:16];
        c_d = g[47:32];
        d_d = g[63:48];
        if (head_i.kind == vsrd_pkg::KIND_FACE) begin
          region_d = 4'({2'd0, row} * 4'd3) + {2'd0, col};
        end
      end
      vsrd_pkg::KIND_AGE, vsrd_pkg::KIND_GENDER: begin
        a_d = {24'd0, g[7:0]};
        b_d = g[23:8];
      end
      vsrd_pkg::KIND_EXPR: begin
        a_d = {24'd0, g[7:0]};
        b_d = {8'd0, g[15:8]};
        c_d = {8'd0, g[23:16]};
        d_d = {8'd0, g[31:24]};
        e_d = g[39:32];
        f_d = g[47:40];
      end
      vsrd_pkg::KIND_RECOG: begin
        a_d = {16'd0, g[15:0]};
        b_d = g[31:16];
        c_d = {15'd0, (g[15:0] <= vsrd_pkg::USER_ID_MAX)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= kind_d;
      a_q      <= a_d;
      b_q      <= b_d;
      c_q      <= c_d;
      d_q      <= d_d;
      e_q      <= e_d;
      f_q      <= f_d;
      region_q <= region_d;
      fe_q     <= head_i.frame_end;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign value_a_o   = a_q;
  assign value_b_o   = b_q;
  assign value_c_o   = c_q;
  assign value_d_o   = d_q;
  assign value_e_o   = e_q;
  assign value_f_o   = f_q;
  assign region_o    = region_q;
  assign frame_end_o = fe_q;

endmodule

`default_nettype wire

>>> rtl/vision_sensor_response_deframer.sv
// Top level of the camera response deframer: configuration registers,
// parser, segment queue and formatter. Depends on vsrd_pkg and the vsrd_* modules.
//
//   channel   direction  handshake               word
//   rx        in         in_valid_i / in_stall_o  rx_byte_i
//   result    out        out_valid_o / out_stall_i kind_o, value_a_o..value_f_o,
//                                                  region_o, frame_end_o
//   config    in         cfg_we_i (no wait)       cfg_index_i, cfg_wdata_i
//
// One byte word is taken every cycle while in_stall_o is low; the byte that closes
// a segment is written into the queue at the edge that takes it, and its result
// word then moves on from the queue into the output register.
// The queue of QUEUE_DEPTH segments lets the parser keep taking bytes while a
// result waits; in_stall_o rises only once the queue is full.
// Reset clears the parser to the header search, empties the queue and restores
// the configuration defaults; no clearing pass is needed.
`default_nettype none

module vision_sensor_response_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       kind_o,
  output logic [31:0]      value_a_o,
  output logic [15:0]      value_b_o,
  output logic [15:0]      value_c_o,
  output logic [15:0]      value_d_o,
  output logic [7:0]       value_e_o,
  output logic [7:0]       value_f_o,
  output logic [3:0]       region_o,
  output logic             frame_end_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i
);

  vsrd_pkg::cfg_t   cfg_q;
  vsrd_pkg::token_t push_token, head_token;
  logic             push, pop, full, empty;

  // Configuration registers; enables keep bit 0 of the written word only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.age_en     <= 1'b1;
      cfg_q.gender_en  <= 1'b1;
      cfg_q.expr_en    <= 1'b1;
      cfg_q.recog_en   <= 1'b1;
      cfg_q.col_left   <= vsrd_pkg::COL_LEFT_RST;
      cfg_q.col_right  <= vsrd_pkg::COL_RIGHT_RST;
      cfg_q.row_top    <= vsrd_pkg::ROW_TOP_RST;
      cfg_q.row_bottom <= vsrd_pkg::ROW_BOTTOM_RST;
    end else if (cfg_we_i) begin
      unique case (vsrd_pkg::reg_idx_e'(cfg_index_i))
        vsrd_pkg::REG_AGE_EN:     cfg_q.age_en     <= cfg_wdata_i[0];
        vsrd_pkg::REG_GENDER_EN:  cfg_q.gender_en  <= cfg_wdata_i[0];
        vsrd_pkg::REG_EXPR_EN:    cfg_q.expr_en    <= cfg_wdata_i[0];
        vsrd_pkg::REG_RECOG_EN:   cfg_q.recog_en   <= cfg_wdata_i[0];
        vsrd_pkg::REG_COL_LEFT:   cfg_q.col_left   <= cfg_wdata_i;
        vsrd_pkg::REG_COL_RIGHT:  cfg_q.col_right  <= cfg_wdata_i;
        vsrd_pkg::REG_ROW_TOP:    cfg_q.row_top    <= cfg_wdata_i;
        vsrd_pkg::REG_ROW_BOTTOM: cfg_q.row_bottom <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Parser: hunt the header, gather segments, push each finished one
  vsrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .token_o    (push_token)
  );

  // Decouple the parser from a stalled result channel
  vsrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_token),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_token)
  );

  // Formatter: unpack, classify the face cell, hold the result word
  vsrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (head_token),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .value_a_o   (value_a_o),
    .value_b_o   (value_b_o),
    .value_c_o   (value_c_o),
    .value_d_o   (value_d_o),
    .value_e_o   (value_e_o),
    .value_f_o   (value_f_o),
    .region_o    (region_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire

>>> sim/vision_sensor_response_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the camera response deframer: feeds byte words, predicts
// the decoded records in its own parser model and compares every result field.
// Depends on vsrd_pkg and the vision_sensor_response_deframer RTL only.

module vision_sensor_response_deframer_tb;
  import vsrd_pkg::*;

  // Parser states of the prediction
  typedef enum logic [2:0] {
    PH_HUNT_FIRST, PH_HUNT_SECOND, PH_LENGTH, PH_COUNTS, PH_BODY, PH_HAND, PH_FACE
  } parse_phase_e;

  typedef enum logic [2:0] {
    PART_BASE, PART_AGE, PART_GENDER, PART_EXPR, PART_RECOG
  } face_part_e;

  // One decoded record as seen on the result channel
  typedef struct packed {
    kind_e       kind;
    logic [31:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [7:0]  e;
    logic [7:0]  f;
    logic [3:0]  region;
    logic        frame_end;
  } record_t;

  // Directed row: a byte word and, where obvious, the record it must produce
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    record_t    rec;
  } dir_row_t;

  localparam int      NUM_PHASES      = 8;
  localparam int      BYTES_PER_PHASE = 250;
  localparam int      DRAIN_LIMIT     = 2000;
  localparam int      LONG_HOLD       = 200;
  localparam record_t NO_REC          = '0;
  localparam record_t HDR_ERR_REC     = '{KIND_ERR, 32'd0, 16'd0, 16'd0, 16'd0,
                                          8'd0, 8'd0, 4'd0, 1'b1};

  // Framing errors first, then a frame with the widest length and no objects
  dir_row_t directed_rows [16] = '{
    '{8'h55, 1'b1, HDR_ERR_REC},   // wrong first header byte
    '{8'hFE, 1'b0, NO_REC},
    '{8'h01, 1'b1, HDR_ERR_REC},   // wrong second header byte
    '{8'hFE, 1'b0, NO_REC},
    '{8'hFE, 1'b1, HDR_ERR_REC},   // repeated first byte fails as second
    '{8'h00, 1'b1, HDR_ERR_REC},   // search restarts, so 0x00 is wrong here
    '{8'hFE, 1'b0, NO_REC},
    '{8'h00, 1'b0, NO_REC},
    '{8'hFF, 1'b0, NO_REC},
    '{8'hFF, 1'b0, NO_REC},
    '{8'hFF, 1'b0, NO_REC},
    '{8'hFF, 1'b1, '{KIND_LEN, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0,
                     4'd0, 1'b0}},
    '{8'h00, 1'b0, NO_REC},
    '{8'h00, 1'b0, NO_REC},
    '{8'h00, 1'b0, NO_REC},
    '{8'hA5, 1'b1, '{KIND_COUNTS, 32'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0,
                     4'd0, 1'b1}}   // all counts zero close the frame
  };

  string field_names [9] = '{"kind", "value_a", "value_b", "value_c", "value_d",
                             "value_e", "value_f", "region", "frame_end"};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  kind_o;
  logic [31:0] value_a_o;
  logic [15:0] value_b_o;
  logic [15:0] value_c_o;
  logic [15:0] value_d_o;
  logic [7:0]  value_e_o;
  logic [7:0]  value_f_o;
  logic [3:0]  region_o;
  logic        frame_end_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_wdata_i;

  // Prediction state: parser position and its own copy of the registers
  parse_phase_e parse_ph;
  face_part_e   face_pt;
  logic [2:0]   byte_pos;
  logic [7:0]   body_left, hand_left, face_left;
  logic [63:0]  gathered;
  cfg_t         pred_cfg;

  record_t     pending_records [$];
  logic [7:0]  stream_bytes [$];
  logic [15:0] next_setting [8];

  int unsigned gap_pct, stall_pct;
  bit          long_hold_due;
  int unsigned mismatches, records_checked, bytes_sent, frames_built, settings_used;
  int unsigned kinds_seen [10];

  vision_sensor_response_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .value_a_o   (value_a_o),
    .value_b_o   (value_b_o),
    .value_c_o   (value_c_o),
    .value_d_o   (value_d_o),
    .value_e_o   (value_e_o),
    .value_f_o   (value_f_o),
    .region_o    (region_o),
    .frame_end_o (frame_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Choose the next object group that still has a count; none left ends the frame
  function automatic void pick_group();
    face_pt = PART_BASE;
    if (body_left != 8'd0) begin
      parse_ph = PH_BODY;
    end else if (hand_left != 8'd0) begin
      parse_ph = PH_HAND;
    end else if (face_left != 8'd0) begin
      parse_ph = PH_FACE;
    end else begin
      parse_ph = PH_HUNT_FIRST;
    end
  endfunction

  // Advance the parser by one byte word; return 1 with the record it completes
  function automatic bit deframe_byte(input logic [7:0] rx, output record_t rec);
    logic [63:0] g;
    int          seg_len, col, row, p;
    bit          on;
    rec = '0;
    if (parse_ph == PH_HUNT_FIRST) begin
      if (rx == HDR_FIRST) begin
        parse_ph = PH_HUNT_SECOND;
        return 1'b0;
      end
      rec.frame_end = 1'b1;
      return 1'b1;
    end
    if (parse_ph == PH_HUNT_SECOND) begin
      if (rx == HDR_SECOND) begin
        parse_ph = PH_LENGTH;
        byte_pos = '0;
        gathered = '0;
        return 1'b0;
      end
      parse_ph      = PH_HUNT_FIRST;
      rec.frame_end = 1'b1;
      return 1'b1;
    end

    case (parse_ph)
      PH_LENGTH, PH_COUNTS: seg_len = 4;
      PH_BODY, PH_HAND:     seg_len = 8;
      default: begin
        case (face_pt)
          PART_AGE, PART_GENDER: seg_len = 3;
          PART_EXPR:             seg_len = 6;
          PART_RECOG:            seg_len = 4;
          default:               seg_len = 8;
        endcase
      end
    endcase

    gathered = gathered | (64'(rx) << (8 * byte_pos));
    if (int'(byte_pos) + 1 < seg_len) begin
      byte_pos++;
      return 1'b0;
    end
    g        = gathered;
    gathered = '0;
    byte_pos = '0;

    case (parse_ph)
      PH_LENGTH: begin
        rec.kind = KIND_LEN;
        rec.a    = g[31:0];
        parse_ph = PH_COUNTS;
      end
      PH_COUNTS: begin
        rec.kind  = KIND_COUNTS;
        body_left = g[7:0];
        hand_left = g[15:8];
        face_left = g[23:16];
        rec.a     = 32'(body_left);
        rec.b     = 16'(hand_left);
        rec.c     = 16'(face_left);
        pick_group();
      end
      PH_BODY, PH_HAND: begin
        rec.kind = (parse_ph == PH_BODY) ? KIND_BODY : KIND_HAND;
        rec.a    = 32'(g[15:0]);
        rec.b    = g[31:16];
        rec.c    = g[47:32];
        rec.d    = g[63:48];
        if (parse_ph == PH_BODY) begin
          body_left--;
        end else begin
          hand_left--;
        end
        pick_group();
      end
      default: begin
        case (face_pt)
          PART_AGE, PART_GENDER: begin
            rec.kind = (face_pt == PART_AGE) ? KIND_AGE : KIND_GENDER;
            rec.a    = 32'(g[7:0]);
            rec.b    = g[23:8];
          end
          PART_EXPR: begin
            rec.kind = KIND_EXPR;
            rec.a    = 32'(g[7:0]);
            rec.b    = 16'(g[15:8]);
            rec.c    = 16'(g[23:16]);
            rec.d    = 16'(g[31:24]);
            rec.e    = g[39:32];
            rec.f    = g[47:40];
          end
          PART_RECOG: begin
            rec.kind = KIND_RECOG;
            rec.a    = 32'(g[15:0]);
            rec.b    = g[31:16];
            rec.c    = (g[15:0] <= USER_ID_MAX) ? 16'd1 : 16'd0;
          end
          default: begin
            rec.kind = KIND_FACE;
            rec.a    = 32'(g[15:0]);
            rec.b    = g[31:16];
            rec.c    = g[47:32];
            rec.d    = g[63:48];
            // first true edge test wins, so out-of-order edges favour the low column and row
            if (g[15:0] <= pred_cfg.col_left) col = 0;
            else if (g[15:0] <= pred_cfg.col_right) col = 1;
            else col = 2;
            if (g[31:16] <= pred_cfg.row_top) row = 0;
            else if (g[31:16] <= pred_cfg.row_bottom) row = 1;
            else row = 2;
            rec.region = 4'(row * 3 + col);
          end
        endcase
        // the next part follows the enables in force right now
        on = 1'b0;
        for (p = int'(face_pt) + 1; p <= int'(PART_RECOG) && !on; p++) begin
          case (face_part_e'(p))
            PART_AGE:    on = pred_cfg.age_en;
            PART_GENDER: on = pred_cfg.gender_en;
            PART_EXPR:   on = pred_cfg.expr_en;
            default:     on = pred_cfg.recog_en;
          endcase
          if (on) begin
            face_pt = face_part_e'(p);
          end
        end
        if (!on) begin
          face_left--;
          pick_group();
        end
      end
    endcase
    rec.frame_end = (parse_ph == PH_HUNT_FIRST);
    return 1'b1;
  endfunction

  // Offer one byte word, hold it until taken, then log what it should produce
  task automatic send_byte(input logic [7:0] rx, input logic typed, input record_t typed_rec);
    record_t rec;
    bit      made;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    made = deframe_byte(rx, rec);
    if (typed) begin
      pending_records.push_back(typed_rec);
    end else if (made) begin
      pending_records.push_back(rec);
    end
    bytes_sent++;
  endtask

  // Wait for every logged record, let the parser settle, then flag any left over
  task automatic drain_records();
    int unsigned w;
    record_t     lost;
    for (w = 0; w < DRAIN_LIMIT && pending_records.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (pending_records.size() != 0) begin
      lost = pending_records.pop_front();
      note_mismatch($sformatf("record of kind %0d never arrived", lost.kind));
    end
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Coordinates cluster round the grid edges so every cell and boundary is hit
  function automatic logic [15:0] coord16(input bit is_x);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3: begin
        if (is_x) return $urandom_range(0, 1) ? pred_cfg.col_left : pred_cfg.col_right;
        return $urandom_range(0, 1) ? pred_cfg.row_top : pred_cfg.row_bottom;
      end
      default: return 16'($urandom_range(0, 1800));
    endcase
  endfunction

  function automatic void push16(input logic [15:0] v);
    stream_bytes.push_back(v[7:0]);
    stream_bytes.push_back(v[15:8]);
  endfunction

  function automatic void push_object();
    push16(coord16(1'b1));
    push16(coord16(1'b0));
    push16(rand16());
    push16(rand16());
  endfunction

  // Result side: check each taken word, then decide the stall for the next cycle
  always @(posedge clk_i) begin : result_side
    record_t     want;
    logic [31:0] got_f [9];
    logic [31:0] want_f [9];
    int unsigned hold_left, burst_left, k;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_records.size() == 0) begin
          note_mismatch($sformatf("unexpected record kind %0d value_a %0h",
                                  kind_o, value_a_o));
        end else begin
          want   = pending_records.pop_front();
          got_f  = '{32'(kind_o), value_a_o, 32'(value_b_o), 32'(value_c_o),
                     32'(value_d_o), 32'(value_e_o), 32'(value_f_o), 32'(region_o),
                     32'(frame_end_o)};
          want_f = '{32'(want.kind), want.a, 32'(want.b), 32'(want.c), 32'(want.d),
                     32'(want.e), 32'(want.f), 32'(want.region), 32'(want.frame_end)};
          for (k = 0; k < 9; k++) begin
            if (got_f[k] !== want_f[k]) begin
              note_mismatch($sformatf("record %0d %s: got %0h, expected %0h",
                                      records_checked, field_names[k], got_f[k], want_f[k]));
            end
          end
          records_checked++;
        end
        if (kind_o <= 4'd9) kinds_seen[kind_o]++;
      end

      // A requested long hold-off lets the block fill up and stall its input
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        burst_left = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned i, ph, n, pick, n_obj, n_face, start, keep;
    logic [31:0] len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'd0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_AGE_EN;
    cfg_wdata_i = 16'd0;
    parse_ph    = PH_HUNT_FIRST;
    face_pt     = PART_BASE;
    byte_pos    = '0;
    body_left   = '0;
    hand_left   = '0;
    face_left   = '0;
    gathered    = '0;
    pred_cfg    = '{1'b1, 1'b1, 1'b1, 1'b1, COL_LEFT_RST, COL_RIGHT_RST,
                    ROW_TOP_RST, ROW_BOTTOM_RST};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset register values
    gap_pct   = 20;
    stall_pct = 20;
    settings_used = 1;
    for (i = 0; i < 16; i++) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].rec);
    end
    in_valid_i <= 1'b0;

    for (ph = 1; ph <= NUM_PHASES; ph++) begin
      drain_records();

      // Pick this phase's registers: all low, all high, edges crossed, then random
      for (i = 0; i < 4; i++) begin
        case (ph)
          1:       next_setting[i] = {15'($urandom), 1'b0};
          2:       next_setting[i] = {15'($urandom), 1'b1};
          default: next_setting[i] = {15'($urandom), $urandom_range(0, 3) != 0};
        endcase
      end
      for (i = 4; i < 8; i += 2) begin
        case (ph)
          1: begin
            next_setting[i]     = 16'h0000;
            next_setting[i + 1] = 16'h0000;
          end
          2: begin
            next_setting[i]     = 16'hFFFF;
            next_setting[i + 1] = 16'hFFFF;
          end
          3: begin
            next_setting[i]     = 16'($urandom_range(800, 1600));
            next_setting[i + 1] = 16'($urandom_range(0, 799));
          end
          default: begin
            next_setting[i]     = 16'($urandom_range(0, 1000));
            next_setting[i + 1] = next_setting[i] + 16'($urandom_range(0, 800));
          end
        endcase
      end

      // Write every register while the block is idle
      for (i = 0; i < 8; i++) begin
        cfg_we_i    <= 1'b1;
        cfg_index_i <= 3'(i);
        cfg_wdata_i <= next_setting[i];
        @(posedge clk_i);
        case (reg_idx_e'(i))
          REG_AGE_EN:    pred_cfg.age_en     = next_setting[i][0];
          REG_GENDER_EN: pred_cfg.gender_en  = next_setting[i][0];
          REG_EXPR_EN:   pred_cfg.expr_en    = next_setting[i][0];
          REG_RECOG_EN:  pred_cfg.recog_en   = next_setting[i][0];
          REG_COL_LEFT:  pred_cfg.col_left   = next_setting[i];
          REG_COL_RIGHT: pred_cfg.col_right  = next_setting[i];
          REG_ROW_TOP:   pred_cfg.row_top    = next_setting[i];
          default:       pred_cfg.row_bottom = next_setting[i];
        endcase
      end
      cfg_we_i <= 1'b0;
      settings_used++;

      // No idling in the last phase; otherwise vary the idle density per phase
      if (ph == NUM_PHASES) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case (ph % 3)
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 15; stall_pct = 20; end
          default: begin gap_pct = 40; stall_pct = 40; end
        endcase
      end

      // Phases cut the word stream anywhere, so register changes land mid-frame too
      for (n = 0; n < BYTES_PER_PHASE; n++) begin
        if (stream_bytes.size() == 0) begin
          pick  = $urandom_range(0, 99);
          start = stream_bytes.size();
          if (pick < 8) begin
            // line noise
            repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom));
          end else if (pick < 12) begin
            // broken header
            stream_bytes.push_back(HDR_FIRST);
            stream_bytes.push_back(8'($urandom_range(1, 255)));
          end else begin
            frames_built++;
            stream_bytes.push_back(HDR_FIRST);
            stream_bytes.push_back(HDR_SECOND);
            case ($urandom_range(0, 5))
              0:       len = 32'h0000_0000;
              1:       len = 32'hFFFF_FFFF;
              default: len = $urandom;
            endcase
            push16(len[15:0]);
            push16(len[31:16]);
            if ($urandom_range(0, 9) == 0) begin
              n_obj  = 0;
              n_face = 0;
              stream_bytes.push_back(8'd0);
              stream_bytes.push_back(8'd0);
            end else begin
              stream_bytes.push_back(8'($urandom_range(0, 2)));
              stream_bytes.push_back(8'($urandom_range(0, 2)));
              n_obj  = stream_bytes[stream_bytes.size() - 2] +
                       stream_bytes[stream_bytes.size() - 1];
              n_face = $urandom_range(0, 3);
            end
            stream_bytes.push_back(8'(n_face));
            stream_bytes.push_back(rand_byte());
            repeat (n_obj) push_object();
            repeat (n_face) begin
              push_object();
              if (pred_cfg.age_en) begin
                stream_bytes.push_back(rand_byte());
                push16(rand16());
              end
              if (pred_cfg.gender_en) begin
                stream_bytes.push_back(rand_byte());
                push16(rand16());
              end
              if (pred_cfg.expr_en) begin
                repeat (6) stream_bytes.push_back(rand_byte());
              end
              if (pred_cfg.recog_en) begin
                push16($urandom_range(0, 1) ? 16'($urandom_range(95, 105)) : rand16());
                push16(rand16());
              end
            end
            // now and then drop the tail of a frame
            if (pick < 15) begin
              keep = $urandom_range(3, stream_bytes.size() - start - 1);
              while (stream_bytes.size() > start + keep) void'(stream_bytes.pop_back());
            end
          end
        end
        send_byte(stream_bytes.pop_front(), 1'b0, NO_REC);
        if (ph == 4 && n == 40) long_hold_due = 1'b1;
      end
      in_valid_i <= 1'b0;
    end

    drain_records();
    $display("summary: %0d words, %0d frames, %0d register settings, %0d records checked",
             bytes_sent, frames_built, settings_used, records_checked);
    $display("summary: records of kind 0 to 9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4],
             kinds_seen[5], kinds_seen[6], kinds_seen[7], kinds_seen[8], kinds_seen[9]);
    if (mismatches == 0) begin
      $display("PASS vision_sensor_response_deframer");
    end else begin
      $display("FAIL vision_sensor_response_deframer");
    end
    $finish;
  end

  // Stop a hung run well beyond the slowest legal one
  initial begin
    #3_000_000;
    $display("FAIL vision_sensor_response_deframer");
    $finish;
  end

endmodule
